// ----- hdl/stt_pkg.sv -----
// Shared types, codes and the byte class table for the source text tokenizer.
`default_nettype none

package stt_pkg;

    // Result kinds
    localparam logic [1:0] KindWord  = 2'd0;
    localparam logic [1:0] KindDelim = 2'd1;
    localparam logic [1:0] KindError = 2'd2;
    localparam logic [1:0] KindEnd   = 2'd3;

    // Literal modes
    localparam logic [1:0] QuoteNone   = 2'd0;
    localparam logic [1:0] QuoteDouble = 2'd1;
    localparam logic [1:0] QuoteSingle = 2'd2;

    localparam logic [7:0] ChEnd       = 8'h00;
    localparam logic [7:0] ChDquote    = 8'h22;
    localparam logic [7:0] ChSquote    = 8'h27;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChNewline   = 8'h0A;
    localparam logic [7:0] ChTab       = 8'h09;
    localparam logic [7:0] ChCr        = 8'h0D;
    localparam logic [7:0] ChSpace     = 8'h20;

    localparam logic [15:0] LineMax = 16'hFFFF;

    typedef enum logic [1:0] {
        ClsWord  = 2'd0,
        ClsBlank = 2'd1,
        ClsDelim = 2'd2
    } t_class;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic        last_of_run;
    } t_result;

    // Results produced by one byte, compacted into the low slots
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic t_class classify(input logic [7:0] b);
        t_class c;
        c = ClsWord;
        case (b)
            ChSpace, ChTab, ChCr: c = ClsBlank;
            8'h2D, 8'h2B, 8'h2A, 8'h2F, 8'h5B, 8'h5D, 8'h7B, 8'h7D,
            8'h3B, 8'h3D, 8'h21, 8'h40, 8'h2C, 8'h24, 8'h7E, 8'h3C,
            8'h3E, 8'h60, 8'h25, 8'h5E, 8'h26, 8'h3A, 8'h28, 8'h29,
            8'h2E, 8'h3F, ChNewline: c = ClsDelim;
            default: c = ClsWord;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/stt_if.sv -----
// Valid/ready channel interfaces for text bytes and token results.
`default_nettype none

interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface stt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;

    modport source (output valid, output kind, output token_start, output token_length,
                    output line_number, output last_of_run, input ready);
    modport sink   (input valid, input kind, input token_start, input token_length,
                    input line_number, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- hdl/stt_core.sv -----
// Tokenizer state and per-byte decision logic.
`default_nettype none

module stt_core
    import stt_pkg::*;
#(
    parameter logic [15:0] POS_LIMIT = 16'hFFFF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    output t_push           o_push
);

    logic [15:0] r_position,   n_position;
    logic [15:0] r_pend_start, n_pend_start;
    logic [1:0]  r_quote,      n_quote;
    logic        r_bs_parity,  n_bs_parity;
    logic [15:0] r_line,       n_line;
    logic        r_err_hold,   n_err_hold;

    logic        is_quote;
    logic [1:0]  quote_kind;
    logic        closing;
    logic [1:0]  quote_mid;
    logic [15:0] start_mid;
    t_class      cls;
    logic        emit_word;
    logic        emit_delim;
    t_result     word_res;
    t_result     delim_res;

    // Decide results and next state for the byte in the input register
    always_comb begin
        is_quote   = (i_byte == ChDquote) || (i_byte == ChSquote);
        quote_kind = (i_byte == ChDquote) ? QuoteDouble : QuoteSingle;
        closing    = is_quote && (r_quote != QuoteNone) && (r_quote == quote_kind);
        cls        = classify(i_byte);

        quote_mid = r_quote;
        start_mid = r_pend_start;
        if (closing) begin
            quote_mid = QuoteNone;
        end else if (is_quote && (r_quote == QuoteNone)) begin
            quote_mid = quote_kind;
            start_mid = r_position;
        end

        emit_word  = (quote_mid == QuoteNone) && (cls != ClsWord) && (r_position > start_mid);
        emit_delim = (quote_mid == QuoteNone) && (cls == ClsDelim);

        word_res.kind         = KindWord;
        word_res.token_start  = start_mid;
        word_res.token_length = r_position - start_mid;
        word_res.line_number  = '0;
        word_res.last_of_run  = !emit_delim;

        delim_res.kind         = KindDelim;
        delim_res.token_start  = r_position;
        delim_res.token_length = 16'd1;
        delim_res.line_number  = '0;
        delim_res.last_of_run  = 1'b1;

        n_position   = r_position;
        n_pend_start = r_pend_start;
        n_quote      = r_quote;
        n_bs_parity  = r_bs_parity;
        n_line       = r_line;
        n_err_hold   = r_err_hold;

        o_push.count = 2'd0;
        o_push.res0  = word_res;
        o_push.res1  = delim_res;

        if (i_fire) begin
            if (i_byte == ChEnd) begin
                // End of text: emit marker, drop everything
                o_push.count             = 2'd1;
                o_push.res0.kind         = KindEnd;
                o_push.res0.token_start  = r_position;
                o_push.res0.token_length = '0;
                o_push.res0.line_number  = '0;
                o_push.res0.last_of_run  = 1'b1;
                n_position   = '0;
                n_pend_start = '0;
                n_quote      = QuoteNone;
                n_bs_parity  = 1'b0;
                n_line       = 16'd1;
                n_err_hold   = 1'b0;
            end else if (r_err_hold) begin
                // Ignore bytes until end of text
                o_push.count = 2'd0;
            end else if (closing && r_bs_parity) begin
                // Escaped closing quote: report and hold
                o_push.count             = 2'd1;
                o_push.res0.kind         = KindError;
                o_push.res0.token_start  = r_position;
                o_push.res0.token_length = '0;
                o_push.res0.line_number  = r_line;
                o_push.res0.last_of_run  = 1'b1;
                n_err_hold = 1'b1;
            end else begin
                o_push.count = 2'({1'b0, emit_word} + {1'b0, emit_delim});
                if (!emit_word) begin
                    o_push.res0 = delim_res;
                end
                n_quote      = quote_mid;
                n_pend_start = start_mid;
                if ((quote_mid == QuoteNone) && (cls != ClsWord)) begin
                    n_pend_start = (r_position < POS_LIMIT) ? r_position + 16'd1 : POS_LIMIT;
                end
                if ((i_byte == ChNewline) && (r_line != LineMax)) begin
                    n_line = r_line + 16'd1;
                end
                n_bs_parity = (i_byte == ChBackslash) ? !r_bs_parity : 1'b0;
                n_position  = (r_position < POS_LIMIT) ? r_position + 16'd1 : POS_LIMIT;
            end
        end
    end

    // Hold tokenizer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position   <= '0;
            r_pend_start <= '0;
            r_quote      <= QuoteNone;
            r_bs_parity  <= 1'b0;
            r_line       <= 16'd1;
            r_err_hold   <= 1'b0;
        end else begin
            r_position   <= n_position;
            r_pend_start <= n_pend_start;
            r_quote      <= n_quote;
            r_bs_parity  <= n_bs_parity;
            r_line       <= n_line;
            r_err_hold   <= n_err_hold;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/stt_result_fifo.sv -----
// Four-entry result queue taking up to two items per cycle, giving one.
`default_nettype none

module stt_result_fifo
    import stt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_push      i_push,
    input  wire logic  i_pop,
    output logic       o_room,
    output logic       o_valid,
    output t_result    o_head
);

    t_result    r_mem [4];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_count, n_count;
    logic       pop;

    assign o_valid = (r_count != 3'd0);
    assign o_head  = r_mem[r_rd];
    assign o_room  = (r_count <= 3'd2);
    assign pop     = i_pop && o_valid;

    // Advance pointers and fill level
    always_comb begin
        n_wr    = r_wr + i_push.count;
        n_rd    = r_rd + {1'b0, pop};
        n_count = r_count + {1'b0, i_push.count} - {2'b00, pop};
    end

    // Write up to two items
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/source_text_tokenizer_unit.sv -----
// Top level of the source text tokenizer.
//
// i_text carries one source byte per item; byte 0 ends the text. o_token
// carries result items: word tokens, delimiter tokens, string errors and
// the end-of-text marker, each with start offset, length and error line.
// A byte gives zero, one or two items; last_of_run marks the final one.
//
// A byte accepted into the input register is decided there and its items
// are written into the result queue, whose head is offered on o_token.
// Throughput: one byte per cycle while each byte gives at most one item
// and o_token is ready; the four-entry result queue drains one item per
// cycle, so both items of a two-item byte pass the output port in turn.
// Input is taken while the input register is empty or its byte can enter
// the queue (at least two free entries).
// Reset clears position and pending start to 0, line to 1, the literal
// mode, backslash parity and error hold, and empties the queue.
// When the receiver stalls, items wait in the queue and the input stops
// once the queue cannot hold two more items.
`default_nettype none

module source_text_tokenizer_unit
    import stt_pkg::*;
#(
    parameter int unsigned MAX_TEXT_BYTES = 65535
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stt_in_if.sink     i_text,
    stt_out_if.source  o_token
);

    localparam logic [15:0] PosLimit =
        (MAX_TEXT_BYTES < 65535) ? 16'(MAX_TEXT_BYTES) : 16'hFFFF;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       room;
    logic       fire;
    t_push      push;
    t_result    head;
    logic       head_valid;

    assign fire         = r_in_valid && room;
    assign i_text.ready = !r_in_valid || room;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.ready && i_text.valid) begin
            r_in_byte <= i_text.text_byte;
        end
    end

    stt_core #(
        .POS_LIMIT (PosLimit)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    stt_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_token.ready),
        .o_room  (room),
        .o_valid (head_valid),
        .o_head  (head)
    );

    // Drive the result channel from the queue head
    assign o_token.valid        = head_valid;
    assign o_token.kind         = head.kind;
    assign o_token.token_start  = head.token_start;
    assign o_token.token_length = head.token_length;
    assign o_token.line_number  = head.line_number;
    assign o_token.last_of_run  = head.last_of_run;

    // End of text always queues its marker
    a_end_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_in_byte == ChEnd) |=> o_token.valid)
        else $error("end marker not queued");

    // Only string errors carry a line number, and it is never zero
    a_line_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_token.valid |-> ((o_token.kind == KindError) == (o_token.line_number != 16'd0)))
        else $error("line number on wrong kind");

    // Delimiters are one byte long and always close their run
    a_delim_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_token.valid && (o_token.kind == KindDelim)
            |-> (o_token.token_length == 16'd1) && o_token.last_of_run)
        else $error("bad delimiter item");

    // A byte only leaves the input register when the queue has room
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count != 2'd0) |-> room)
        else $error("result queue overflow");

endmodule

`default_nettype wire
